### sv/god_pkg.sv
// Shared types and constants of the glyph outline decoder.
package god_pkg;

  localparam int MaxPoints   = 64;
  localparam int MaxContours = 16;
  localparam int PtAw        = $clog2(MaxPoints);
  localparam int PtW         = $clog2(MaxPoints + 1);
  localparam int CtAw        = $clog2(MaxContours);
  localparam int CtW         = $clog2(MaxContours + 1);
  localparam int QueueDepth  = 2;

  localparam logic [1:0] StPoint    = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StCompound = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] x;
    logic [15:0] y;
    logic        on_flag;
    logic [3:0]  contour_index;
    logic        contour_end;
    logic        last;
  } result_t;

endpackage

### sv/god_in_queue.sv
// Input byte queue between the stream slave port and the parse engine.
module god_in_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  god_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output god_pkg::item_t rd_item_o
);

  localparam int Aw = $clog2(god_pkg::QueueDepth);
  localparam int Cw = $clog2(god_pkg::QueueDepth + 1);

  god_pkg::item_t mem_q [god_pkg::QueueDepth];
  logic [Aw-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0]  count_q, count_d;
  logic           push, pop;

  assign wr_ready_o = (count_q != Cw'(god_pkg::QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Aw'(god_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Aw'(god_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

### sv/god_engine.sv
// Parse engine: header, end indices, flags, x and y deltas, point output register.
module god_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  god_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output god_pkg::result_t out_res_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEAD, PH_ENDS, PH_ILEN, PH_ISKIP, PH_FLAG, PH_REP, PH_XS, PH_YS
  } phase_e;

  typedef enum logic [2:0] {
    ST_BYTE, ST_REP, ST_ADVX, ST_PT, ST_DRAIN, ST_FIN
  } state_e;

  localparam int PtAw = god_pkg::PtAw;
  localparam int PtW  = god_pkg::PtW;
  localparam int CtAw = god_pkg::CtAw;
  localparam int CtW  = god_pkg::CtW;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [3:0]     fbc_q, fbc_d;
  logic [7:0]     phb_q, phb_d;
  logic [15:0]    ct_q, ct_d;
  logic [15:0]    lo_q, lo_d;
  logic [15:0]    hi_q, hi_d;
  logic [15:0]    skip_q, skip_d;
  logic [7:0]     rep_q, rep_d;
  logic [15:0]    rc_q, rc_d;
  logic [PtW-1:0] total_q, total_d;
  logic [PtW-1:0] pc_q, pc_d;
  logic [CtW-1:0] cc_q, cc_d;
  logic [4:0]     last_flag_q, last_flag_d;
  logic [1:0]     fin_st_q, fin_st_d;
  logic           out_valid_q, out_valid_d;
  god_pkg::result_t out_res_q, out_res_d;

  logic [15:0] ends_q [god_pkg::MaxContours];
  logic        ends_we;
  logic [15:0] ends_wdata;

  logic [4:0]  flag_mem [god_pkg::MaxPoints];
  logic [15:0] x_mem [god_pkg::MaxPoints];
  logic [4:0]  flag_q;
  logic [15:0] x_q;
  logic        flag_we, x_we;
  logic [4:0]  flag_wdata;
  logic [15:0] x_wdata;
  logic [PtAw-1:0] waddr, raddr;

  logic        slot_free, take, start;
  phase_e      ph;
  logic [3:0]  fbc;
  logic [7:0]  b;
  logic [15:0] v;
  logic [16:0] v_inc;
  logic        sh_bit, same_bit, coord_done;
  logic [15:0] ends_rd;
  logic        at_end, fin_pt, pc_lt_total;
  logic [4:0]  f5;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_BYTE);
  assign take        = in_valid_i && in_ready_o;
  assign start       = in_item_i.start;
  assign b           = in_item_i.data;
  assign ph          = start ? PH_HEAD : phase_q;
  assign fbc         = start ? 4'd0 : fbc_q;
  assign v           = {phb_q, b};
  assign v_inc       = {1'b0, v} + 17'd1;
  assign f5          = {b[5], b[4], b[2:0]};
  assign ends_rd     = ends_q[cc_q[CtAw-1:0]];
  assign pc_lt_total = (pc_q < total_q);
  assign at_end      = ({{(16-PtW){1'b0}}, pc_q} == ends_rd);
  assign fin_pt      = ((pc_q + 1'b1) == total_q);
  assign waddr       = pc_q[PtAw-1:0];
  assign raddr       = pc_d[PtAw-1:0];
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign sh_bit      = (ph == PH_XS) ? flag_q[1] : flag_q[2];
  assign same_bit    = (ph == PH_XS) ? flag_q[3] : flag_q[4];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fbc_d       = fbc_q;
    phb_d       = phb_q;
    ct_d        = ct_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    skip_d      = skip_q;
    rep_d       = rep_q;
    rc_d        = rc_q;
    total_d     = total_q;
    pc_d        = pc_q;
    cc_d        = cc_q;
    last_flag_d = last_flag_q;
    fin_st_d    = fin_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    ends_we     = 1'b0;
    ends_wdata  = v;
    flag_we     = 1'b0;
    flag_wdata  = f5;
    x_we        = 1'b0;
    x_wdata     = rc_q;
    coord_done  = 1'b0;

    unique case (state_q)
      ST_BYTE: begin
        if (take && (start || phase_q != PH_IDLE)) begin
          phase_d = ph;
          fbc_d   = fbc;
          unique case (ph)
            PH_HEAD: begin
              if (!fbc[0]) begin
                phb_d = b;
                fbc_d = fbc + 4'd1;
              end else begin
                if (fbc == 4'd1) ct_d = v;
                if (fbc == 4'd5) lo_d = v;
                if (fbc == 4'd9) hi_d = v;
                if (fbc < 4'd9) begin
                  fbc_d = fbc + 4'd1;
                end else begin
                  fbc_d = 4'd0;
                  if (ct_q == 16'd0) begin
                    fin_st_d = god_pkg::StEmpty;
                    phase_d  = PH_IDLE;
                    state_d  = ST_FIN;
                  end else if (ct_q[15]) begin
                    fin_st_d = god_pkg::StCompound;
                    phase_d  = PH_IDLE;
                    state_d  = ST_FIN;
                  end else if (ct_q > 16'(god_pkg::MaxContours)) begin
                    fin_st_d = god_pkg::StOverflow;
                    phase_d  = PH_IDLE;
                    state_d  = ST_FIN;
                  end else begin
                    phase_d = PH_ENDS;
                    cc_d    = '0;
                  end
                end
              end
            end
            PH_ENDS: begin
              if (fbc == 4'd0) begin
                phb_d = b;
                fbc_d = 4'd1;
              end else begin
                fbc_d   = 4'd0;
                ends_we = 1'b1;
                cc_d    = cc_q + 1'b1;
                if ({{(16-CtW){1'b0}}, cc_d} >= ct_q) begin
                  if (v_inc > 17'(god_pkg::MaxPoints)) begin
                    fin_st_d = god_pkg::StOverflow;
                    phase_d  = PH_IDLE;
                    state_d  = ST_FIN;
                  end else begin
                    total_d = v_inc[PtW-1:0];
                    phase_d = PH_ILEN;
                  end
                end
              end
            end
            PH_ILEN: begin
              if (fbc == 4'd0) begin
                phb_d = b;
                fbc_d = 4'd1;
              end else begin
                fbc_d   = 4'd0;
                skip_d  = v;
                pc_d    = '0;
                phase_d = (v != 16'd0) ? PH_ISKIP : PH_FLAG;
              end
            end
            PH_ISKIP: begin
              skip_d = skip_q - 16'd1;
              if (skip_d == 16'd0) begin
                pc_d    = '0;
                phase_d = PH_FLAG;
              end
            end
            PH_FLAG: begin
              flag_we     = 1'b1;
              last_flag_d = f5;
              pc_d        = pc_q + 1'b1;
              if (b[3]) begin
                phase_d = PH_REP;
              end else if (pc_d >= total_q) begin
                phase_d = PH_XS;
                pc_d    = '0;
                rc_d    = '0;
                fbc_d   = 4'd0;
                state_d = ST_ADVX;
              end
            end
            PH_REP: begin
              rep_d   = b;
              state_d = ST_REP;
            end
            PH_XS, PH_YS: begin
              if (sh_bit) begin
                rc_d       = same_bit ? rc_q + {8'd0, b} : rc_q - {8'd0, b};
                coord_done = 1'b1;
              end else if (fbc == 4'd0) begin
                phb_d = b;
                fbc_d = 4'd1;
              end else begin
                rc_d       = rc_q + v;
                fbc_d      = 4'd0;
                coord_done = 1'b1;
              end
              if (coord_done) begin
                if (ph == PH_XS) begin
                  x_we    = 1'b1;
                  x_wdata = rc_d;
                  pc_d    = pc_q + 1'b1;
                  state_d = ST_ADVX;
                end else begin
                  state_d = ST_PT;
                end
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      ST_REP: begin
        if (rep_q != 8'd0 && pc_lt_total) begin
          flag_we    = 1'b1;
          flag_wdata = last_flag_q;
          pc_d       = pc_q + 1'b1;
          rep_d      = rep_q - 8'd1;
        end else begin
          rep_d = 8'd0;
          if (!pc_lt_total) begin
            phase_d = PH_XS;
            pc_d    = '0;
            rc_d    = '0;
            fbc_d   = 4'd0;
            state_d = ST_ADVX;
          end else begin
            phase_d = PH_FLAG;
            state_d = ST_BYTE;
          end
        end
      end
      ST_ADVX: begin
        if (pc_lt_total && !flag_q[1] && flag_q[3]) begin
          x_we = 1'b1;
          pc_d = pc_q + 1'b1;
        end else if (!pc_lt_total) begin
          phase_d = PH_YS;
          pc_d    = '0;
          cc_d    = '0;
          rc_d    = '0;
          fbc_d   = 4'd0;
          state_d = ST_DRAIN;
        end else begin
          state_d = ST_BYTE;
        end
      end
      ST_PT, ST_DRAIN: begin
        if (state_q == ST_DRAIN && !(pc_lt_total && !flag_q[2] && flag_q[4])) begin
          state_d = ST_BYTE;
        end else if (slot_free) begin
          out_valid_d             = 1'b1;
          out_res_d.status        = god_pkg::StPoint;
          out_res_d.x             = x_q;
          out_res_d.y             = hi_q - (rc_q - lo_q);
          out_res_d.on_flag       = flag_q[0];
          out_res_d.contour_index = cc_q[3:0];
          out_res_d.contour_end   = at_end || fin_pt;
          out_res_d.last          = fin_pt;
          if (at_end && ({{(16-CtW){1'b0}}, cc_q} + 16'd1 < ct_q)) begin
            cc_d = cc_q + 1'b1;
          end
          pc_d = pc_q + 1'b1;
          if (fin_pt) begin
            phase_d = PH_IDLE;
            state_d = ST_BYTE;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_res_d        = '0;
          out_res_d.status = fin_st_q;
          out_res_d.last   = 1'b1;
          state_d          = ST_BYTE;
        end
      end
      default: begin
        state_d = ST_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BYTE;
      phase_q     <= PH_IDLE;
      fbc_q       <= '0;
      phb_q       <= '0;
      ct_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      skip_q      <= '0;
      rep_q       <= '0;
      rc_q        <= '0;
      total_q     <= '0;
      pc_q        <= '0;
      cc_q        <= '0;
      last_flag_q <= '0;
      fin_st_q    <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fbc_q       <= fbc_d;
      phb_q       <= phb_d;
      ct_q        <= ct_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      skip_q      <= skip_d;
      rep_q       <= rep_d;
      rc_q        <= rc_d;
      total_q     <= total_d;
      pc_q        <= pc_d;
      cc_q        <= cc_d;
      last_flag_q <= last_flag_d;
      fin_st_q    <= fin_st_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ends_we) begin
      ends_q[cc_q[CtAw-1:0]] <= ends_wdata;
    end
  end

  // flag and x stores: registered read of the next cursor, write forwarded
  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[waddr] <= flag_wdata;
    end
    if (x_we) begin
      x_mem[waddr] <= x_wdata;
    end
    flag_q <= (flag_we && waddr == raddr) ? flag_wdata : flag_mem[raddr];
    x_q    <= (x_we && waddr == raddr) ? x_wdata : x_mem[raddr];
  end

endmodule

### sv/glyph_outline_decoder.sv
// Top level of the simple-glyph outline decoder.
// Input stream: one record byte per request in s_axis_tdata_i, tuser marks the
// first byte of a record. A two-entry queue takes bytes while the engine works.
// Output stream: one request per point, or one status result (empty, compound,
// overflow) per rejected record; tlast marks the final result of a record.
// Steps: header, end-index, skip and flag bytes are parsed as they are taken;
// a flag repeat count copies the last flag once per repeat; complete flags
// then store each leading byte-less x; an x byte that finishes a
// coordinate stores it and then each following byte-less x; the last x
// starts the y pass, which emits each leading byte-less point; a y byte that
// finishes a coordinate emits its point and then each following byte-less point.
// A full output register makes the engine wait.
// Reset clears the parser to idle and the output register to empty; bytes
// not marked as a record start are then dropped. A stalled receiver holds
// the output register; the engine stops when it has a result to place and
// the queue then fills and lowers s_axis_tready_o.
module glyph_outline_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // glyph_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // point_x, point_y, on-curve flag, contour_index,
                                        // contour_end, zero pad
  output logic [1:0]  m_axis_tuser_o,   // status
  output logic        m_axis_tlast_o
);

  god_pkg::item_t   wr_item, rd_item;
  god_pkg::result_t res;
  logic             rd_valid, rd_ready;

  assign wr_item.start = s_axis_tuser_i;
  assign wr_item.data  = s_axis_tdata_i;

  god_in_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid_i),
    .wr_ready_o (s_axis_tready_o),
    .wr_item_i  (wr_item),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_item_o  (rd_item)
  );

  god_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_valid),
    .in_ready_o  (rd_ready),
    .in_item_i   (rd_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {2'b00, res.contour_end, res.contour_index, res.on_flag,
                           res.y, res.x};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

endmodule

### sv/god_checker.sv
// Port-level checks of the glyph outline decoder, bound to the top level.
module god_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output request dropped or changed under stall");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != god_pkg::StPoint |-> m_axis_tlast_o)
    else $error("status result without last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != god_pkg::StPoint |-> m_axis_tdata_o == '0)
    else $error("status result with point data");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && m_axis_tuser_o == god_pkg::StPoint
      |-> m_axis_tdata_o[37])
    else $error("final point without contour end");

endmodule

bind glyph_outline_decoder god_checker u_god_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### tb/tb.sv
// Self-checking testbench for the simple-glyph outline decoder.
`timescale 1ns / 100ps

module tb;

  localparam int WatchLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int RunCap     = 64;
  localparam int NDir       = 31;

  typedef enum int {
    PH_IDLE, PH_HEAD, PH_ENDS, PH_ILEN, PH_ISKIP, PH_FLAG, PH_REP, PH_XS, PH_YS
  } phase_e;

  typedef enum int {GEN_RANDOM, GEN_LONG_RUN, GEN_PT_OVERFLOW, GEN_CUT} gen_e;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       typed;
    logic [1:0] st;
  } dir_row_t;

  // idle byte, empty glyph, compound, too many contours; box at the extremes
  localparam dir_row_t DirTab [NDir] = '{
    '{1'b0, 8'hA5, 1'b0, god_pkg::StPoint},
    '{1'b1, 8'h00, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h00, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h80, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h00, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h7F, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hFF, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'hFF, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hFF, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h00, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h00, 1'b1, god_pkg::StEmpty},
    '{1'b1, 8'hFF, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hFF, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h00, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h00, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h00, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h00, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'hFF, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hFF, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h7F, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hFF, 1'b1, god_pkg::StCompound},
    '{1'b1, 8'h00, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h11, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h12, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h34, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h56, 1'b0, god_pkg::StPoint}, '{1'b0, 8'h78, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'h9A, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hBC, 1'b0, god_pkg::StPoint},
    '{1'b0, 8'hDE, 1'b0, god_pkg::StPoint}, '{1'b0, 8'hF0, 1'b1, god_pkg::StOverflow}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // data_byte
  logic        s_axis_tuser_i;   // glyph_start
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;   // point_x, point_y, on-curve flag, contour_index,
                                 // contour_end, zero pad
  logic [1:0]  m_axis_tuser_o;   // status
  logic        m_axis_tlast_o;

  glyph_outline_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  god_pkg::item_t   byte_q [$];
  logic             typed_q [$];
  god_pkg::result_t point_q [$];
  god_pkg::result_t step_pts [$];
  int      mismatches = 0;
  int      results_seen = 0;
  bit      quiet = 1'b0;

  // ---------------------------------------------------------------- decoder model
  phase_e      ph;
  int          fcnt, n_pts, pcur, ccur, nres;
  logic [7:0]  hi_b;
  logic [15:0] n_cont, y_lo, y_hi, skip_n, acc;
  logic [15:0] ends [god_pkg::MaxContours];
  logic [4:0]  flags [god_pkg::MaxPoints];
  logic [15:0] xs [god_pkg::MaxPoints];

  function automatic bit x_free(logic [4:0] f);
    return !f[1] && f[3];
  endfunction

  function automatic bit y_free(logic [4:0] f);
    return !f[2] && f[4];
  endfunction

  task automatic push_pt(logic [1:0] st, logic [15:0] x, logic [15:0] y, logic on,
                         logic [3:0] ci, logic ce, logic lst);
    god_pkg::result_t r;
    r.status = st; r.x = x; r.y = y; r.on_flag = on;
    r.contour_index = ci; r.contour_end = ce; r.last = lst;
    step_pts = {step_pts, r};
    nres++;
  endtask

  task automatic reject(logic [1:0] st);
    push_pt(st, '0, '0, 1'b0, '0, 1'b0, 1'b1);
    ph = PH_IDLE;
  endtask

  task automatic advance_x();
    while (pcur < n_pts && x_free(flags[pcur])) begin
      xs[pcur] = acc;
      pcur++;
    end
    if (pcur >= n_pts) begin
      ph = PH_YS; pcur = 0; ccur = 0; acc = '0; fcnt = 0;
    end
  endtask

  task automatic start_x();
    ph = PH_XS; pcur = 0; acc = '0; fcnt = 0;
    advance_x();
  endtask

  task automatic emit_point();
    bit at_end, fin;
    logic [15:0] y;
    at_end = (pcur == int'(ends[ccur]));
    fin = (pcur + 1 == n_pts);
    y = y_hi - (acc - y_lo);
    push_pt(god_pkg::StPoint, xs[pcur], y, flags[pcur][0], ccur[3:0], at_end || fin, fin);
    if (at_end && ccur + 1 < int'(n_cont)) ccur++;
    pcur++;
    if (fin) ph = PH_IDLE;
  endtask

  task automatic drain_y();
    while (ph == PH_YS && pcur < n_pts && y_free(flags[pcur]) && nres < RunCap)
      emit_point();
  endtask

  // short values add or subtract by the same bit, long ones are two bytes
  task automatic coord_add(logic [4:0] f, int sb, int mb, logic [7:0] b, output bit done);
    done = 1'b0;
    if (f[sb]) begin
      acc = f[mb] ? acc + {8'd0, b} : acc - {8'd0, b};
      done = 1'b1;
    end else if (fcnt == 0) begin
      hi_b = b; fcnt = 1;
    end else begin
      acc = acc + {hi_b, b};
      fcnt = 0;
      done = 1'b1;
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic start);
    logic [15:0] v;
    bit done;
    int k;
    step_pts.delete();
    nres = 0;
    if (start) begin
      ph = PH_HEAD; fcnt = 0;
    end else if (ph == PH_IDLE) begin
      return;
    end else if (ph == PH_YS) begin
      drain_y();
      if (ph != PH_YS || y_free(flags[pcur])) return;
    end
    v = {hi_b, b};
    case (ph)
      PH_HEAD: begin
        if (fcnt % 2 == 0) begin
          hi_b = b; fcnt++;
        end else begin
          if (fcnt == 1) n_cont = v;
          else if (fcnt == 5) y_lo = v;
          else if (fcnt == 9) y_hi = v;
          if (fcnt < 9) fcnt++;
          else begin
            fcnt = 0;
            if (n_cont == 0) begin reject(god_pkg::StEmpty); return; end
            if (n_cont[15]) begin reject(god_pkg::StCompound); return; end
            if (n_cont > god_pkg::MaxContours) begin
              reject(god_pkg::StOverflow); return;
            end
            ph = PH_ENDS; ccur = 0;
          end
        end
      end
      PH_ENDS: begin
        if (fcnt == 0) begin
          hi_b = b; fcnt = 1;
        end else begin
          fcnt = 0;
          ends[ccur] = v;
          ccur++;
          if (ccur >= int'(n_cont)) begin
            n_pts = int'(v) + 1;
            if (n_pts > god_pkg::MaxPoints) begin reject(god_pkg::StOverflow); return; end
            ph = PH_ILEN;
          end
        end
      end
      PH_ILEN: begin
        if (fcnt == 0) begin
          hi_b = b; fcnt = 1;
        end else begin
          fcnt = 0; skip_n = v; pcur = 0;
          ph = (skip_n != 0) ? PH_ISKIP : PH_FLAG;
        end
      end
      PH_ISKIP: begin
        skip_n--;
        if (skip_n == 0) begin pcur = 0; ph = PH_FLAG; end
      end
      PH_FLAG: begin
        flags[pcur] = {b[5:4], b[2:0]};
        pcur++;
        if (b[3]) ph = PH_REP;
        else if (pcur >= n_pts) start_x();
      end
      PH_REP: begin
        k = int'(b);
        while (k > 0 && pcur < n_pts) begin
          flags[pcur] = flags[pcur-1];
          pcur++; k--;
        end
        if (pcur >= n_pts) start_x();
        else ph = PH_FLAG;
      end
      PH_XS: begin
        coord_add(flags[pcur], 1, 3, b, done);
        if (done) begin
          xs[pcur] = acc; pcur++;
          advance_x();
        end
      end
      PH_YS: begin
        coord_add(flags[pcur], 2, 4, b, done);
        if (done && nres < RunCap) emit_point();
      end
      default: ph = PH_IDLE;
    endcase
    if (ph == PH_YS) drain_y();
  endtask

  // ------------------------------------------------------------ record builder
  task automatic add_byte(ref god_pkg::item_t rec [$], input logic [7:0] b, input logic s);
    god_pkg::item_t it;
    it.start = s; it.data = b;
    rec = {rec, it};
  endtask

  task automatic gen_glyph(gen_e mode);
    god_pkg::item_t rec [$];
    int r, nc, np, ilen, p, k, c;
    int ends_l [god_pkg::MaxContours];
    logic [7:0] f;
    logic [7:0] fl [god_pkg::MaxPoints];
    r = $urandom_range(0, 99);
    if (mode == GEN_RANDOM && r < 6) begin
      // rejected header with random box
      case (r % 3)
        0: nc = 0;
        1: nc = 16'h8000 | $urandom_range(0, 16'h7FFF);
        default: nc = $urandom_range(god_pkg::MaxContours + 1, 16'h7FFF);
      endcase
      add_byte(rec, nc[15:8], 1'b1);
      add_byte(rec, nc[7:0], 1'b0);
      repeat (8) add_byte(rec, 8'($urandom), 1'b0);
      byte_q = {byte_q, rec};
      repeat (10) typed_q = {typed_q, 1'b0};
      return;
    end
    nc = (r < 85) ? $urandom_range(1, 3) : $urandom_range(1, god_pkg::MaxContours);
    np = (r < 80) ? $urandom_range(1, 6) : $urandom_range(1, god_pkg::MaxPoints);
    if (mode == GEN_LONG_RUN) np = god_pkg::MaxPoints;
    if (mode == GEN_PT_OVERFLOW)
      np = $urandom_range(god_pkg::MaxPoints + 1, god_pkg::MaxPoints + 40);
    add_byte(rec, 8'h00, 1'b1);
    add_byte(rec, nc[7:0], 1'b0);
    repeat (8) add_byte(rec, 8'($urandom), 1'b0);
    p = 0;
    for (c = 0; c < nc - 1; c++) begin
      p = p + $urandom_range(0, 2);
      ends_l[c] = (p < np) ? p : np - 1;
      if (r % 7 == 0) ends_l[c] = $urandom_range(0, 16'hFFFF);
    end
    ends_l[nc-1] = np - 1;
    for (c = 0; c < nc; c++) begin
      add_byte(rec, 8'(ends_l[c] >> 8), 1'b0);
      add_byte(rec, 8'(ends_l[c]), 1'b0);
    end
    if (np <= god_pkg::MaxPoints) begin
      ilen = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
      add_byte(rec, 8'(ilen >> 8), 1'b0);
      add_byte(rec, 8'(ilen), 1'b0);
      repeat (ilen) add_byte(rec, 8'($urandom), 1'b0);
      p = 0;
      while (p < np) begin
        f = 8'($urandom);
        if (mode == GEN_LONG_RUN) f = {2'b00, 6'b110001};
        if (mode == GEN_LONG_RUN || $urandom_range(0, 3) == 0) begin
          k = (mode == GEN_LONG_RUN) ? 255 : $urandom_range(0, np - p + 2);
          add_byte(rec, f | 8'h08, 1'b0);
          add_byte(rec, 8'(k), 1'b0);
          for (c = 0; c <= k && p < np; c++) fl[p++] = f;
        end else begin
          add_byte(rec, f & 8'hF7, 1'b0);
          fl[p++] = f;
        end
      end
      for (p = 0; p < np; p++) begin
        if (fl[p][1]) add_byte(rec, 8'($urandom), 1'b0);
        else if (!fl[p][4]) repeat (2) add_byte(rec, 8'($urandom), 1'b0);
      end
      for (p = 0; p < np; p++) begin
        if (fl[p][2]) add_byte(rec, 8'($urandom), 1'b0);
        else if (!fl[p][5]) repeat (2) add_byte(rec, 8'($urandom), 1'b0);
      end
    end
    // a cut record is broken off by the next start mark
    if (mode == GEN_CUT || $urandom_range(0, 19) == 0)
      rec = rec[0:$urandom_range(1, rec.size() - 1)];
    byte_q = {byte_q, rec};
    repeat (rec.size()) typed_q = {typed_q, 1'b0};
    if ($urandom_range(0, 9) == 0) begin
      f = 8'($urandom);
      add_byte(byte_q, f, 1'b0);
      typed_q = {typed_q, 1'b0};
    end
  endtask

  // ------------------------------------------------------------------- clocking
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int idle;
    god_pkg::result_t exp_r;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    ph = PH_IDLE; fcnt = 0; hi_b = '0; n_cont = '0; y_lo = '0; y_hi = '0;
    skip_n = '0; acc = '0; n_pts = 0; pcur = 0; ccur = 0;
    for (int i = 0; i < NDir; i++) begin
      add_byte(byte_q, DirTab[i].data, DirTab[i].start);
      typed_q = {typed_q, DirTab[i].typed};
    end
    gen_glyph(GEN_LONG_RUN);
    gen_glyph(GEN_PT_OVERFLOW);
    gen_glyph(GEN_CUT);
    while (byte_q.size() < NDir + 300) gen_glyph(GEN_RANDOM);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle = 0;
    for (int i = 0; i < byte_q.size(); i++) begin
      if (i >= byte_q.size() - 40) quiet = 1'b1;
      if (!quiet && idle == 0 && $urandom_range(0, 4) == 0) idle = $urandom_range(1, 6);
      if (idle > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
        idle = 0;
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= byte_q[i].data;
      s_axis_tuser_i  <= byte_q[i].start;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      decode_byte(byte_q[i].data, byte_q[i].start);
      if (typed_q[i]) begin
        // typed-in status row
        exp_r = '{status: DirTab[i].st, x: '0, y: '0, on_flag: 1'b0,
                  contour_index: '0, contour_end: 1'b0, last: 1'b1};
        point_q = {point_q, exp_r};
      end else begin
        point_q = {point_q, step_pts};
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // ------------------------------------------------------------ result side
  int hold = 0;
  int ridle = 0;
  bit held_once = 1'b0;

  always @(posedge clk_i) begin
    god_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tuser_o;
      got.x = m_axis_tdata_o[15:0];
      got.y = m_axis_tdata_o[31:16];
      got.on_flag = m_axis_tdata_o[32];
      got.contour_index = m_axis_tdata_o[36:33];
      got.contour_end = m_axis_tdata_o[37];
      got.last = m_axis_tlast_o;
      results_seen++;
      if (point_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = point_q.pop_front();
        if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
            got.on_flag !== want.on_flag || got.contour_index !== want.contour_index ||
            got.contour_end !== want.contour_end || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    // one long hold-off so the input queue fills and backs up
    if (!held_once && results_seen >= 20) begin
      held_once = 1'b1;
      hold = HoldCycles;
    end
    if (hold > 0) begin
      hold--;
      m_axis_tready_i <= 1'b0;
    end else if (quiet || !rst_ni) begin
      m_axis_tready_i <= rst_ni;
    end else if (ridle > 0) begin
      ridle--;
      m_axis_tready_i <= 1'b0;
    end else if ((results_seen / 32) % 3 != 2 && $urandom_range(0, 4) == 0) begin
      ridle = $urandom_range(0, 5);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // watchdog: cycles with no request moving on either side
  initial begin
    int still;
    still = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        still = 0;
      else
        still++;
      if (still >= WatchLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
